FILE: hw/rtl/lrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrp_pkg
// shared constants and types for the true-lru replacement block
// ----------------------------------------------------------------------------
package lrp_pkg;

  localparam int LRP_MAX_ENTRIES = 64;
  localparam int LRP_ENTRIES_DEF = 16;
  localparam int LRP_IDX_W       = $clog2(LRP_MAX_ENTRIES);
  localparam int LRP_KEY_W       = 32;
  localparam int LRP_CAP_W       = 5;
  localparam int LRP_SLOT_W      = 4;
  localparam int LRP_OUT_W       = 40;
  localparam logic [LRP_CAP_W-1:0] LRP_CAP_RESET = 5'd16;

  // search record handed from cell to cell
  typedef struct packed {
    logic                 tok;
    logic [LRP_KEY_W-1:0] key;
    logic                 found;
    logic [LRP_IDX_W-1:0] match_idx;
    logic [LRP_IDX_W-1:0] match_rank;
    logic                 free_found;
    logic [LRP_IDX_W-1:0] free_idx;
    logic                 best_found;
    logic [LRP_IDX_W-1:0] best_idx;
    logic [LRP_IDX_W-1:0] best_rank;
    logic [LRP_KEY_W-1:0] best_key;
  } lrp_rec_t;

  // update command broadcast to every cell
  typedef struct packed {
    logic                 upd;
    logic                 write;
    logic                 age_all;
    logic [LRP_IDX_W-1:0] winner;
    logic [LRP_IDX_W-1:0] limit;
    logic [LRP_KEY_W-1:0] key;
  } lrp_cmd_t;

endpackage

FILE: hw/rtl/lrp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrp_cell
// one table entry: key, valid and age rank, plus one stage of the scan chain
// ----------------------------------------------------------------------------
module lrp_cell #(
  parameter int IDX    = 0,
  parameter int RANK_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lrp_pkg::lrp_rec_t rec_in,
  output lrp_pkg::lrp_rec_t rec_out,
  input  lrp_pkg::lrp_cmd_t cmd
);

  localparam logic [lrp_pkg::LRP_IDX_W-1:0] MY_IDX = lrp_pkg::LRP_IDX_W'(IDX);

  logic                          valid_r;
  logic [lrp_pkg::LRP_KEY_W-1:0] key_r;
  logic [RANK_W-1:0]             rank_r;
  lrp_pkg::lrp_rec_t             rec_r;
  lrp_pkg::lrp_rec_t             rec_nxt;
  logic [lrp_pkg::LRP_IDX_W-1:0] rank_ext;

  assign rank_ext = lrp_pkg::LRP_IDX_W'(rank_r);

  always_comb begin
    rec_nxt = rec_in;
    if (valid_r && !rec_in.found && key_r == rec_in.key) begin
      rec_nxt.found      = 1'b1;
      rec_nxt.match_idx  = MY_IDX;
      rec_nxt.match_rank = rank_ext;
    end
    if (!valid_r && !rec_in.free_found) begin
      rec_nxt.free_found = 1'b1;
      rec_nxt.free_idx   = MY_IDX;
    end
    // strict compare keeps the lowest-numbered entry on a tie
    if (valid_r && (!rec_in.best_found || rank_ext > rec_in.best_rank)) begin
      rec_nxt.best_found = 1'b1;
      rec_nxt.best_idx   = MY_IDX;
      rec_nxt.best_rank  = rank_ext;
      rec_nxt.best_key   = key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else begin
      rec_r <= rec_nxt;
    end
  end

  assign rec_out = rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else if (cmd.upd) begin
      if (cmd.winner == MY_IDX) begin
        rank_r <= '0;
        if (cmd.write) begin
          valid_r <= 1'b1;
        end
      end else if (valid_r && (cmd.age_all || rank_ext < cmd.limit)) begin
        rank_r <= rank_r + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && cmd.write && cmd.winner == MY_IDX) begin
      key_r <= cmd.key;
    end
  end

endmodule

FILE: hw/rtl/lru_replacement_policy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_replacement_policy
// true-lru replacement for a small fully associative key table
// ----------------------------------------------------------------------------
// the search record walks the chain of entry cells one cell per cycle; a new
//   item is taken only in the idle state, after the result of the last one
//   has been registered
// a finished result may wait in the output register while the next item is taken
// reset (rst_n low, synchronous): table empty, all ranks zero, fill count zero,
//   capacity_in_use back to 16, no result pending
module lru_replacement_policy #(
  parameter int ENTRIES = lrp_pkg::LRP_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // access items
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // [31:0] access_key
  // result items
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lrp_pkg::LRP_OUT_W-1:0] out_tdata,  // [0] hit, [4:1] slot,
                                                    // [5] evicted, [37:6] victim_key
  // configuration
  input  logic                          cfg_wen,
  input  logic [4:0]                    cfg_wdata   // capacity_in_use
);

  localparam int RANK_W = $clog2(ENTRIES);
  localparam int FC_W   = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (FC_W > lrp_pkg::LRP_CAP_W) ? FC_W : lrp_pkg::LRP_CAP_W;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [lrp_pkg::LRP_CAP_W-1:0] cap_r;
  logic [FC_W-1:0]               fill_cnt_r;
  lrp_pkg::lrp_rec_t             dec_r;
  logic                          out_valid_r;
  logic [lrp_pkg::LRP_OUT_W-1:0] out_data_r;

  lrp_pkg::lrp_rec_t             inject;
  lrp_pkg::lrp_rec_t             chain [ENTRIES];
  lrp_pkg::lrp_cmd_t             cmd;

  logic                          in_acc;
  logic                          out_free;
  logic                          finish;
  logic [CMP_W-1:0]              cap_ext;
  logic [CMP_W-1:0]              eff_cap;
  logic                          can_fill;
  logic                          do_fill;
  logic                          do_evict;
  logic [lrp_pkg::LRP_IDX_W-1:0] slot_idx;
  logic [lrp_pkg::LRP_OUT_W-1:0] result;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign finish    = (state_r == S_DONE) && out_free;

  // fresh search record enters cell 0 on acceptance
  always_comb begin
    inject     = '0;
    inject.tok = in_acc;
    inject.key = in_tdata;
  end

  // chain of entry cells, record hops one cell per cycle
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      lrp_cell #(.IDX(i), .RANK_W(RANK_W)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .rec_in  (inject),
        .rec_out (chain[i]),
        .cmd     (cmd)
      );
    end else begin : g_body
      lrp_cell #(.IDX(i), .RANK_W(RANK_W)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .rec_in  (chain[i-1]),
        .rec_out (chain[i]),
        .cmd     (cmd)
      );
    end
  end

  // capacity of zero acts as one, above table size acts as table size
  always_comb begin
    cap_ext = CMP_W'(cap_r);
    if (cap_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign can_fill = CMP_W'(fill_cnt_r) < eff_cap;

  // decision from the finished record: hit, fill a free entry, or evict lru
  always_comb begin
    do_fill  = 1'b0;
    do_evict = 1'b0;
    cmd      = '0;
    cmd.key  = dec_r.key;
    if (dec_r.found) begin
      slot_idx  = dec_r.match_idx;
      cmd.limit = dec_r.match_rank;
    end else if (can_fill && dec_r.free_found) begin
      do_fill     = 1'b1;
      slot_idx    = dec_r.free_idx;
      cmd.write   = 1'b1;
      cmd.age_all = 1'b1;
    end else begin
      do_evict    = 1'b1;
      slot_idx    = dec_r.best_idx;
      cmd.write   = 1'b1;
      cmd.age_all = 1'b1;
    end
    cmd.winner = slot_idx;
    cmd.upd    = finish;
  end

  assign result = {2'b00,
                   do_evict ? dec_r.best_key : {lrp_pkg::LRP_KEY_W{1'b0}},
                   do_evict,
                   slot_idx[lrp_pkg::LRP_SLOT_W-1:0],
                   dec_r.found};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_SCAN;
      S_SCAN: if (chain[ENTRIES-1].tok) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= lrp_pkg::LRP_CAP_RESET;
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wen) begin
        cap_r <= cfg_wdata;
      end
      if (finish && do_fill) begin
        fill_cnt_r <= fill_cnt_r + FC_W'(1);
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_SCAN && chain[ENTRIES-1].tok) begin
      dec_r <= chain[ENTRIES-1];
    end
    if (finish) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: hw/rtl/lrp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrp_checker
// port-level checks for the lru replacement block, bound to the top level
// ----------------------------------------------------------------------------
module lrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // victim key is zero unless an eviction happened
  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[5] |-> out_tdata[37:6] == 32'd0)
    else $error("victim key set without eviction");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[5]))
    else $error("hit and eviction together");

  // one item at a time: no new accept right after one, no result the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !$rose(out_tvalid))
    else $error("second item or early result after accept");

endmodule

bind lru_replacement_policy lrp_checker u_lrp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the true-lru replacement block against its own table model: every
// access item is mirrored into a shadow key table with lru ranks, and each
// result item is compared with the lookup that the shadow table predicts
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_ENTRIES  = lrp_pkg::LRP_ENTRIES_DEF;
  localparam int DRAIN_CYCLES = NUM_ENTRIES + 6;
  localparam int IDLE_LIMIT   = 4000;
  localparam int LONG_HOLD    = 400;
  localparam int POOL_DEPTH   = 24;
  localparam logic [lrp_pkg::LRP_CAP_W-1:0] LATE_CAPS [6] =
    '{5'd16, 5'd17, 5'd1, 5'd0, 5'd24, 5'd31};

  typedef struct packed {
    logic                           hit;
    logic [lrp_pkg::LRP_SLOT_W-1:0] slot;
    logic                           evicted;
    logic [lrp_pkg::LRP_KEY_W-1:0]  victim_key;
  } lookup_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MASK} rx_mode_t;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [31:0]                   in_tdata   = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [lrp_pkg::LRP_OUT_W-1:0] out_tdata;
  logic                          cfg_wen    = 1'b0;
  logic [lrp_pkg::LRP_CAP_W-1:0] cfg_wdata  = '0;

  lru_replacement_policy #(
    .ENTRIES(NUM_ENTRIES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow key table
  logic                          tbl_valid [NUM_ENTRIES];
  logic [lrp_pkg::LRP_KEY_W-1:0] tbl_key   [NUM_ENTRIES];
  int unsigned                   tbl_rank  [NUM_ENTRIES];
  int unsigned                   tbl_fill;
  logic [lrp_pkg::LRP_CAP_W-1:0] tbl_cap;

  lookup_t     pending_lookups [$];
  logic [31:0] access_q [$];
  logic [31:0] key_pool [POOL_DEPTH];
  logic        in_fire_q    = 1'b0;
  int          err_cnt      = 0;
  int          items_taken  = 0;
  int          items_pushed = 0;
  int          results_seen = 0;
  int          idle_cycles  = 0;

  // every other valid entry younger than limit gets one step older
  function automatic void age_entries(int winner, int unsigned limit);
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (i != winner && tbl_valid[i] && tbl_rank[i] < limit) tbl_rank[i]++;
    tbl_rank[winner] = 0;
  endfunction

  function automatic lookup_t lru_access(logic [lrp_pkg::LRP_KEY_W-1:0] key);
    lookup_t     res;
    int          idx;
    int unsigned eff_cap;
    res = '0;
    idx = -1;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--)
      if (tbl_valid[i] && tbl_key[i] == key) idx = i;
    if (idx >= 0) begin
      res.hit = 1'b1;
      age_entries(idx, tbl_rank[idx]);
    end else begin
      eff_cap = (tbl_cap == 0) ? 1 : (tbl_cap > NUM_ENTRIES) ? NUM_ENTRIES : tbl_cap;
      if (tbl_fill < eff_cap) begin
        // lowest free entry
        for (int i = NUM_ENTRIES - 1; i >= 0; i--)
          if (!tbl_valid[i]) idx = i;
        tbl_valid[idx] = 1'b1;
        tbl_fill++;
      end else begin
        // oldest valid entry, lowest index on a tie
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (tbl_valid[i] && (idx < 0 || tbl_rank[i] > tbl_rank[idx])) idx = i;
        res.evicted    = 1'b1;
        res.victim_key = tbl_key[idx];
      end
      age_entries(idx, 32'hFFFF_FFFF);
      tbl_key[idx] = key;
    end
    res.slot = idx[lrp_pkg::LRP_SLOT_W-1:0];
    return res;
  endfunction

  // monitor: compare results first, then predict the item taken at this edge
  always @(posedge clk) begin
    lookup_t want, got;
    in_fire_q <= rst_n && in_tvalid && in_tready;
    if (!rst_n) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        tbl_valid[i] = 1'b0;
        tbl_key[i]   = '0;
        tbl_rank[i]  = 0;
      end
      tbl_fill = 0;
      tbl_cap  = lrp_pkg::LRP_CAP_RESET;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        got = {out_tdata[0], out_tdata[4:1], out_tdata[5], out_tdata[37:6]};
        if (pending_lookups.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: result item with nothing pending: hit=%0d slot=%0d",
                     $time, got.hit, got.slot, " evicted=%0d victim=%08h",
                     got.evicted, got.victim_key);
        end else begin
          want = pending_lookups.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("%0t: result error: expected hit=%0d slot=%0d evicted=%0d victim=%08h",
                       $time, want.hit, want.slot, want.evicted, want.victim_key);
              $display("%0t:   got hit=%0d slot=%0d evicted=%0d victim=%08h",
                       $time, got.hit, got.slot, got.evicted, got.victim_key);
            end
          end
        end
      end
      if (cfg_wen) tbl_cap = cfg_wdata;
      if (in_tvalid && in_tready) begin
        pending_lookups.push_back(lru_access(in_tdata));
        items_taken++;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("lru_replacement_policy: mismatch");
      $finish;
    end
  end

  // driver: bursts of items with random gaps, some stretches gap-free
  int burst_left = 0;
  int gap_left   = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire_q) begin
      if (gap_left > 0 || access_q.size() == 0) begin
        in_tvalid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= access_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end
      end
    end
  end

  // receiver: stall pattern of its own, plus long hold-offs while items wait
  rx_mode_t   rx_mode    = RX_OPEN;
  int         rx_left    = 0;
  int         hold_cnt   = 0;
  int         long_holds = 0;
  logic [7:0] rx_mask    = 8'hFF;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt--;
    end else if (long_holds < 2 && items_taken >= 200 + 700 * long_holds &&
                 access_q.size() > 8) begin
      out_tready <= 1'b0;
      hold_cnt = LONG_HOLD - 1;
      long_holds++;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 200);
        rx_mask = 8'($urandom);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 5) == 0);
        default: begin
          out_tready <= rx_mask[0];
          rx_mask = {rx_mask[0], rx_mask[7:1]};
        end
      endcase
    end
  end

  task automatic push_key(logic [31:0] key);
    access_q.push_back(key);
    items_pushed++;
  endtask

  // wait until every pushed item has come back, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    while (results_seen != items_pushed) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(logic [lrp_pkg::LRP_CAP_W-1:0] value);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // mostly keys from a small pool so hits and lru order matter, some fresh keys
  task automatic random_phase(int count, int pool_sz);
    for (int i = 0; i < 4; i++) key_pool[$urandom_range(0, POOL_DEPTH - 1)] = $urandom;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 19))
        0, 1, 2: push_key($urandom);
        3:       push_key($urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF);
        default: push_key(key_pool[$urandom_range(0, pool_sz - 1)]);
      endcase
    end
  endtask

  initial begin
    logic [lrp_pkg::LRP_CAP_W-1:0] cap;
    for (int i = 0; i < POOL_DEPTH; i++) key_pool[i] = $urandom;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // capacity zero acts as one: fill, replace with victim key zero, hit, replace again
    write_capacity(5'd0);
    push_key(32'h0000_0000);
    push_key(32'hFFFF_FFFF);
    push_key(32'hFFFF_FFFF);
    push_key(32'h0000_0000);
    drain();

    // capacity two: hit the kept entry, fill a second one, then replace the older entry
    write_capacity(5'd2);
    push_key(32'h0000_0000);
    push_key(32'hA5A5_A5A5);
    push_key(32'h5A5A_5A5A);
    drain();

    // low capacities while the table still has free entries
    for (int p = 0; p < 4; p++) begin
      cap = 5'(3 + 3 * p);
      write_capacity(cap);
      random_phase(80, cap + $urandom_range(0, 4));
      drain();
    end

    // capacity above table size: fill every entry, evict, hit middle and oldest
    write_capacity(5'd31);
    for (int i = 1; i <= 14; i++) push_key(i * 32'h1111_1111);
    push_key(32'h0000_0001);
    push_key(32'h3333_3333);
    push_key(32'h5A5A_5A5A);
    drain();

    // full table under assorted capacities, lowered ones included
    for (int p = 0; p < 12; p++) begin
      cap = (p < 6) ? LATE_CAPS[p] : 5'($urandom_range(0, 31));
      write_capacity(cap);
      random_phase(100, $urandom_range(2, POOL_DEPTH));
      drain();
    end

    if (err_cnt == 0 && pending_lookups.size() == 0) begin
      $display("lru_replacement_policy: match");
    end else begin
      $display("lru_replacement_policy: mismatch");
    end
    $finish;
  end

endmodule
